// ===== sv/stma_pkg.sv =====
// Shared types and constants for the sparse triplet matrix adder.
// Used by stma_front, stma_back and sparse_triplet_matrix_add; no dependencies.
package stma_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 32;
    localparam int INDEX_BITS  = 16;

    // Fixed field widths
    localparam int ACT_W     = 2;
    localparam int FIELD_W   = 16;
    localparam int VAL_W     = 32;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    // Stored index width: the index fields are kept to INDEX_BITS bits
    localparam int IDX_W  = (INDEX_BITS < FIELD_W) ? INDEX_BITS : FIELD_W;
    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd1;

    typedef enum logic [ACT_W-1:0] {
        ACT_LOAD  = 2'd0,
        ACT_MERGE = 2'd1,
        ACT_EMIT  = 2'd2
    } action_t;

    // One queued request
    typedef struct packed {
        action_t            action;
        logic [IDX_W-1:0]   row;
        logic [IDX_W-1:0]   col;
        logic [VAL_W-1:0]   value;
    } cmd_t;

    // One table entry as held in the RAM
    typedef struct packed {
        logic [IDX_W-1:0]   row;
        logic [IDX_W-1:0]   col;
        logic [VAL_W-1:0]   value;
    } entry_t;

    // Queue head as seen by the back end
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } head_t;

    // One result toward the output ports
    typedef struct packed {
        logic               valid;
        logic               is_header;
        logic [FIELD_W-1:0] row;
        logic [FIELD_W-1:0] col;
        logic [VAL_W-1:0]   value;
        logic               overflowed;
        logic               last;
    } result_t;

endpackage

// ===== sv/stma_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module stma_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/stma_front.sv =====
// Front end: accepts requests, drops meaningless actions, queues the rest.
// Depends on stma_pkg.
module stma_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [stma_pkg::ACT_W-1:0]    action,
    input  logic [stma_pkg::FIELD_W-1:0]  row_index,
    input  logic [stma_pkg::FIELD_W-1:0]  col_index,
    input  logic [stma_pkg::VAL_W-1:0]    elem_value,
    output stma_pkg::head_t               head,
    input  logic                          pop
);

    stma_pkg::cmd_t              q_reg [stma_pkg::QUEUE_DEPTH];
    logic [stma_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [stma_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [stma_pkg::QCNT_W-1:0] cnt_reg, cnt_next;
    logic                        accept;
    logic                        known;
    logic                        push;
    logic                        do_pop;
    stma_pkg::cmd_t              new_cmd;

    assign busy   = (cnt_reg == stma_pkg::QCNT_W'(stma_pkg::QUEUE_DEPTH));
    assign accept = start && !busy;

    // Classify: action code 3 has no meaning and is dropped here
    always_comb
    begin
        case (action)
            stma_pkg::ACT_LOAD,
            stma_pkg::ACT_MERGE,
            stma_pkg::ACT_EMIT:  known = 1'b1;
            default:             known = 1'b0;
        endcase
    end

    assign push   = accept && known;
    assign do_pop = pop && (cnt_reg != '0);

    assign new_cmd.action = stma_pkg::action_t'(action);
    assign new_cmd.row    = row_index[stma_pkg::IDX_W-1:0];
    assign new_cmd.col    = col_index[stma_pkg::IDX_W-1:0];
    assign new_cmd.value  = elem_value;

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == stma_pkg::QPTR_W'(stma_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == stma_pkg::QPTR_W'(stma_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Queue storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= new_cmd;
        end
    end

    assign head.valid = (cnt_reg != '0);
    assign head.cmd   = q_reg[rd_ptr_reg];

endmodule

// ===== sv/stma_back.sv =====
// Back end: executes queued requests against the triplet table RAM.
// Depends on stma_pkg and stma_ram.
module stma_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  stma_pkg::head_t              head,
    output logic                         pop,
    input  logic [stma_pkg::CFG_W-1:0]   matrix_rows,
    input  logic [stma_pkg::CFG_W-1:0]   matrix_cols,
    output stma_pkg::result_t            res
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_HDR  = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

    state_t                       state_reg, state_next;
    logic [stma_pkg::CNT_W-1:0]   count_reg, count_next;
    logic                         ovf_reg, ovf_next;
    logic [stma_pkg::CNT_W-1:0]   i_reg, i_next;
    logic                         pend_reg, pend_next;
    logic [stma_pkg::ADDR_W-1:0]  pend_idx_reg, pend_idx_next;
    stma_pkg::cmd_t               cmd_reg, cmd_next;
    stma_pkg::result_t            res_reg, res_next;

    logic                         ram_we;
    logic [stma_pkg::ADDR_W-1:0]  ram_waddr;
    stma_pkg::entry_t             ram_wdata;
    stma_pkg::entry_t             rd_entry;
    logic                         append_req;
    stma_pkg::entry_t             append_entry;
    logic                         match;

    stma_ram #(
        .WIDTH ($bits(stma_pkg::entry_t)),
        .DEPTH (stma_pkg::TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (i_reg[stma_pkg::ADDR_W-1:0]),
        .rdata (rd_entry)
    );

    // Read data of the previous cycle's address matches the merge key
    assign match = pend_reg && (rd_entry.row == cmd_reg.row) && (rd_entry.col == cmd_reg.col);

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        ovf_next      = ovf_reg;
        i_next        = i_reg;
        pend_next     = 1'b0;
        pend_idx_next = pend_idx_reg;
        cmd_next      = cmd_reg;
        res_next      = '0;
        pop           = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = count_reg[stma_pkg::ADDR_W-1:0];
        ram_wdata     = rd_entry;
        append_req    = 1'b0;
        append_entry.row   = cmd_reg.row;
        append_entry.col   = cmd_reg.col;
        append_entry.value = cmd_reg.value;

        case (state_reg)
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    pop      = 1'b1;
                    cmd_next = head.cmd;
                    i_next   = '0;
                    case (head.cmd.action)
                        stma_pkg::ACT_LOAD:
                        begin
                            append_req         = 1'b1;
                            append_entry.row   = head.cmd.row;
                            append_entry.col   = head.cmd.col;
                            append_entry.value = head.cmd.value;
                        end
                        stma_pkg::ACT_MERGE: state_next = ST_SCAN;
                        stma_pkg::ACT_EMIT:  state_next = ST_HDR;
                        default:             state_next = ST_IDLE;
                    endcase
                end
            end

            // One entry compared per cycle, reads pipelined one ahead
            ST_SCAN:
            begin
                if (match)
                begin
                    ram_we          = 1'b1;
                    ram_waddr       = pend_idx_reg;
                    ram_wdata.row   = rd_entry.row;
                    ram_wdata.col   = rd_entry.col;
                    ram_wdata.value = rd_entry.value + cmd_reg.value;
                    state_next      = ST_IDLE;
                end
                else if (i_reg < count_reg)
                begin
                    pend_next     = 1'b1;
                    pend_idx_next = i_reg[stma_pkg::ADDR_W-1:0];
                    i_next        = i_reg + 1'b1;
                end
                else if (!pend_reg)
                begin
                    append_req = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            // Header while the first entry is read
            ST_HDR:
            begin
                res_next.valid      = 1'b1;
                res_next.is_header  = 1'b1;
                res_next.row        = matrix_rows;
                res_next.col        = matrix_cols;
                res_next.value      = stma_pkg::VAL_W'(count_reg);
                res_next.overflowed = ovf_reg;
                res_next.last       = (count_reg == '0);
                if (count_reg != '0)
                begin
                    pend_next     = 1'b1;
                    pend_idx_next = '0;
                    i_next        = stma_pkg::CNT_W'(1);
                    state_next    = ST_EMIT;
                end
                else
                begin
                    count_next = '0;
                    ovf_next   = 1'b0;
                    state_next = ST_IDLE;
                end
            end

            // Stream entries one per cycle, then clear the table
            ST_EMIT:
            begin
                res_next.valid      = 1'b1;
                res_next.is_header  = 1'b0;
                res_next.row        = stma_pkg::FIELD_W'(rd_entry.row);
                res_next.col        = stma_pkg::FIELD_W'(rd_entry.col);
                res_next.value      = rd_entry.value;
                res_next.overflowed = 1'b0;
                res_next.last       = (stma_pkg::CNT_W'(pend_idx_reg) + 1'b1 == count_reg);
                if (i_reg < count_reg)
                begin
                    pend_next     = 1'b1;
                    pend_idx_next = i_reg[stma_pkg::ADDR_W-1:0];
                    i_next        = i_reg + 1'b1;
                end
                else
                begin
                    count_next = '0;
                    ovf_next   = 1'b0;
                    state_next = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase

        // Append at the fill point, or flag the drop when full
        if (append_req)
        begin
            if (count_reg < stma_pkg::CNT_W'(stma_pkg::TABLE_DEPTH))
            begin
                ram_we     = 1'b1;
                ram_waddr  = count_reg[stma_pkg::ADDR_W-1:0];
                ram_wdata  = append_entry;
                count_next = count_reg + 1'b1;
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            i_reg     <= '0;
            pend_reg  <= 1'b0;
            res_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            i_reg     <= i_next;
            pend_reg  <= pend_next;
            res_reg   <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg <= pend_idx_next;
        cmd_reg      <= cmd_next;
    end

    assign res = res_reg;

    // Fill count never passes the table depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= stma_pkg::CNT_W'(stma_pkg::TABLE_DEPTH))
        else $error("entry count beyond table depth");

    // Results only come out of the emit states
    a_res_source: assert property (@(posedge clk) disable iff (!rst_n)
        res_reg.valid |-> ($past(state_reg) == ST_HDR || $past(state_reg) == ST_EMIT))
        else $error("result outside emit run");

    // The final result of a run leaves the table empty and the engine idle
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (res_reg.valid && res_reg.last) |-> (state_reg == ST_IDLE && count_reg == '0 && !ovf_reg))
        else $error("emit run ended without clearing");

    // A scan never reports a match without an outstanding read
    a_match_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && match) |-> $past(pend_next))
        else $error("match on stale read data");

endmodule

// ===== sv/sparse_triplet_matrix_add.sv =====
// Sparse matrix adder in triplet form: top level with configuration registers.
// Depends on stma_pkg, stma_front, stma_back (and stma_ram below it).
//
// Usage:
//   A request is taken at a rising edge with start high and busy low. action 0
//   appends a triplet, 1 merges one (adds to the entry with the same row and
//   column, else appends), 2 emits a header and all entries, then clears.
//   Action code 3 is accepted and ignored. busy rises only when the two-deep
//   request queue in front of the table engine is full.
//   Timing: the engine takes a request from the queue once it is idle, and a
//   load is written into the table in the cycle the engine takes it. A merge
//   compares one stored entry at a time through the table RAM's single read
//   port. An emit presents one result per cycle, and each result is registered
//   before it reaches the ports.
//   Results: result_valid is high for one cycle per result; the receiver
//   cannot stall. Configuration: cfg_we writes cfg_data to register cfg_index
//   (0 rows, 1 columns), other indexes ignored; write only while idle.
//   Reset: clears the queue, entry count, overflow flag and both registers;
//   table contents are kept, and entries past the count are never read.
module sparse_triplet_matrix_add (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [stma_pkg::ACT_W-1:0]        action,
    input  logic [stma_pkg::FIELD_W-1:0]      row_index,
    input  logic [stma_pkg::FIELD_W-1:0]      col_index,
    input  logic signed [stma_pkg::VAL_W-1:0] elem_value,
    input  logic                              cfg_we,
    input  logic [stma_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [stma_pkg::CFG_W-1:0]        cfg_data,
    output logic                              result_valid,
    output logic                              is_header,
    output logic [stma_pkg::FIELD_W-1:0]      out_row,
    output logic [stma_pkg::FIELD_W-1:0]      out_col,
    output logic signed [stma_pkg::VAL_W-1:0] out_value,
    output logic                              overflowed,
    output logic                              last_result
);

    logic [stma_pkg::CFG_W-1:0] rows_reg;
    logic [stma_pkg::CFG_W-1:0] cols_reg;
    stma_pkg::head_t            head;
    logic                       pop;
    stma_pkg::result_t          res;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= '0;
            cols_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                stma_pkg::CFG_ROWS: rows_reg <= cfg_data;
                stma_pkg::CFG_COLS: cols_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    stma_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .action     (action),
        .row_index  (row_index),
        .col_index  (col_index),
        .elem_value ($unsigned(elem_value)),
        .head       (head),
        .pop        (pop)
    );

    stma_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .pop         (pop),
        .matrix_rows (rows_reg),
        .matrix_cols (cols_reg),
        .res         (res)
    );

    // Result ports
    assign result_valid = res.valid;
    assign is_header    = res.is_header;
    assign out_row      = res.row;
    assign out_col      = res.col;
    assign out_value    = $signed(res.value);
    assign overflowed   = res.overflowed;
    assign last_result  = res.last;

endmodule

// ===== test/stma_checker.sv =====
// Result checker for sparse_triplet_matrix_add: watches the request, register and
// result ports, keeps its own triplet table and compares every result in order.
// Depends on stma_pkg only.
`timescale 1ns / 1ps

module stma_checker
    import stma_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  logic [ACT_W-1:0]     action,
    input  logic [FIELD_W-1:0]   row_index,
    input  logic [FIELD_W-1:0]   col_index,
    input  logic [VAL_W-1:0]     elem_value,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 result_valid,
    input  logic                 is_header,
    input  logic [FIELD_W-1:0]   out_row,
    input  logic [FIELD_W-1:0]   out_col,
    input  logic [VAL_W-1:0]     out_value,
    input  logic                 overflowed,
    input  logic                 last_result,
    output int                   pending,
    output int                   errors,
    output int                   requests,
    output int                   merge_hits,
    output int                   results,
    output int                   overflow_headers
);

    // One emitted word: header or table entry
    typedef struct packed {
        logic               is_header;
        logic [FIELD_W-1:0] row;
        logic [FIELD_W-1:0] col;
        logic [VAL_W-1:0]   value;
        logic               overflowed;
        logic               last;
    } emit_word_t;

    // Running sum table, kept in insertion order
    logic [IDX_W-1:0] sum_row [TABLE_DEPTH];
    logic [IDX_W-1:0] sum_col [TABLE_DEPTH];
    logic [VAL_W-1:0] sum_val [TABLE_DEPTH];
    int               sum_count;
    logic             sum_ovf;
    logic [CFG_W-1:0] hdr_rows;
    logic [CFG_W-1:0] hdr_cols;
    emit_word_t       emit_q [$];

    // Append, or flag the overflow when the table is full
    task automatic store_triplet(input logic [IDX_W-1:0] r, input logic [IDX_W-1:0] c,
                                 input logic [VAL_W-1:0] v);
        if (sum_count >= TABLE_DEPTH)
        begin
            sum_ovf = 1'b1;
        end
        else
        begin
            sum_row[sum_count] = r;
            sum_col[sum_count] = c;
            sum_val[sum_count] = v;
            sum_count++;
        end
    endtask

    // Apply one accepted request to the table; emits queue the expected words
    task automatic apply_request(input logic [ACT_W-1:0] act,
                                 input logic [FIELD_W-1:0] r_in,
                                 input logic [FIELD_W-1:0] c_in,
                                 input logic [VAL_W-1:0] v);
        logic [IDX_W-1:0] r;
        logic [IDX_W-1:0] c;
        bit               hit;
        r   = r_in[IDX_W-1:0];
        c   = c_in[IDX_W-1:0];
        hit = 1'b0;
        case (act)
            ACT_LOAD:
            begin
                requests++;
                store_triplet(r, c, v);
            end
            ACT_MERGE:
            begin
                requests++;
                // first matching entry takes the sum, wrapping at 32 bits
                for (int i = 0; i < sum_count; i++)
                begin
                    if (!hit && sum_row[i] == r && sum_col[i] == c)
                    begin
                        sum_val[i] = sum_val[i] + v;
                        hit = 1'b1;
                    end
                end
                if (hit)
                    merge_hits++;
                else
                    store_triplet(r, c, v);
            end
            ACT_EMIT:
            begin
                requests++;
                emit_q.push_back({1'b1, FIELD_W'(hdr_rows), FIELD_W'(hdr_cols),
                                  VAL_W'(sum_count), sum_ovf, sum_count == 0});
                for (int i = 0; i < sum_count; i++)
                    emit_q.push_back({1'b0, FIELD_W'(sum_row[i]), FIELD_W'(sum_col[i]),
                                      sum_val[i], 1'b0, i + 1 == sum_count});
                sum_count = 0;
                sum_ovf   = 1'b0;
            end
            default: ;  // unused action code: no effect
        endcase
    endtask

    // Compare one result with the oldest expected word
    task automatic check_result();
        emit_word_t got;
        emit_word_t want;
        got = {is_header, out_row, out_col, out_value, overflowed, last_result};
        results++;
        if (emit_q.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("[%0t] unexpected result: hdr=%0b row=%h col=%h val=%h ovf=%0b last=%0b",
                         $realtime, got.is_header, got.row, got.col, got.value,
                         got.overflowed, got.last);
        end
        else
        begin
            want = emit_q.pop_front();
            if (got !== want)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("[%0t] result mismatch", $realtime);
                    $display("    expected hdr=%0b row=%h col=%h val=%h ovf=%0b last=%0b",
                             want.is_header, want.row, want.col, want.value,
                             want.overflowed, want.last);
                    $display("    actual   hdr=%0b row=%h col=%h val=%h ovf=%0b last=%0b",
                             got.is_header, got.row, got.col, got.value,
                             got.overflowed, got.last);
                end
            end
            else if (got.is_header && got.overflowed)
            begin
                overflow_headers++;
            end
        end
    endtask

    // All ports sampled at the rising edge, before the testbench drives new values
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_count        = 0;
            sum_ovf          = 1'b0;
            hdr_rows         = '0;
            hdr_cols         = '0;
            errors           = 0;
            requests         = 0;
            merge_hits       = 0;
            results          = 0;
            overflow_headers = 0;
            emit_q.delete();
        end
        else
        begin
            if (result_valid)
                check_result();
            if (cfg_we)
            begin
                if (cfg_index == CFG_ROWS)
                    hdr_rows = cfg_data;
                else if (cfg_index == CFG_COLS)
                    hdr_cols = cfg_data;
            end
            if (start && !busy)
                apply_request(action, row_index, col_index, elem_value);
        end
        pending = emit_q.size();
    end

endmodule

// ===== test/tb.sv =====
// Testbench top for sparse_triplet_matrix_add: clock, reset, request and register
// stimulus, and the verdict. Depends on stma_pkg, the block and stma_checker.
`timescale 1ns / 1ps

module tb;
    import stma_pkg::*;

    localparam int RANDOM_ITEMS = 480;
    localparam int DRAIN_CYCLES = 120;
    localparam int CYCLE_LIMIT  = 500000;

    // Action code with no meaning, and register indexes the block ignores
    localparam logic [ACT_W-1:0]     ACT_NONE     = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 start        = 1'b0;
    logic [ACT_W-1:0]     action       = '0;
    logic [FIELD_W-1:0]   row_index    = '0;
    logic [FIELD_W-1:0]   col_index    = '0;
    logic [VAL_W-1:0]     elem_value   = '0;
    logic                 cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index    = '0;
    logic [CFG_W-1:0]     cfg_data     = '0;
    logic                 busy;
    logic                 result_valid;
    logic                 is_header;
    logic [FIELD_W-1:0]   out_row;
    logic [FIELD_W-1:0]   out_col;
    logic [VAL_W-1:0]     out_value;
    logic                 overflowed;
    logic                 last_result;

    int pending;
    int errors;
    int requests;
    int merge_hits;
    int results;
    int overflow_headers;

    int          cycles = 0;
    int          sent_items = 0;
    bit          steady = 1'b0;
    logic [31:0] placed_coords [$];

    sparse_triplet_matrix_add dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .row_index    (row_index),
        .col_index    (col_index),
        .elem_value   (elem_value),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .is_header    (is_header),
        .out_row      (out_row),
        .out_col      (out_col),
        .out_value    (out_value),
        .overflowed   (overflowed),
        .last_result  (last_result)
    );

    stma_checker chk (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .action           (action),
        .row_index        (row_index),
        .col_index        (col_index),
        .elem_value       (elem_value),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .result_valid     (result_valid),
        .is_header        (is_header),
        .out_row          (out_row),
        .out_col          (out_col),
        .out_value        (out_value),
        .overflowed       (overflowed),
        .last_result      (last_result),
        .pending          (pending),
        .errors           (errors),
        .requests         (requests),
        .merge_hits       (merge_hits),
        .results          (results),
        .overflow_headers (overflow_headers)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("** sparse_triplet_matrix_add: FAILED **");
            $finish;
        end
    end

    // Issue one request; returns at the edge that accepts it, start still high
    task automatic send(input logic [ACT_W-1:0] act, input logic [FIELD_W-1:0] r,
                        input logic [FIELD_W-1:0] c, input logic [VAL_W-1:0] v);
        int gap;
        bit taken;
        gap = steady ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start      <= 1'b1;
        action     <= act;
        row_index  <= r;
        col_index  <= c;
        elem_value <= v;
        // busy is stable around the falling edge
        do
        begin
            @(negedge clk);
            taken = !busy;
            @(posedge clk);
        end
        while (!taken);
        if (act != ACT_NONE)
            sent_items++;
    endtask

    // Stop issuing, wait for every expected result, then let the engine settle
    task automatic drain();
        start <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Both registers plus a write to an index the block ignores
    task automatic write_config(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols,
                                input logic [CFG_IDX_W-1:0] spare_idx,
                                input logic [CFG_W-1:0] spare_data);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_ROWS;
        cfg_data  <= rows;
        @(posedge clk);
        cfg_index <= spare_idx;
        cfg_data  <= spare_data;
        @(posedge clk);
        cfg_index <= CFG_COLS;
        cfg_data  <= cols;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [FIELD_W-1:0] pick_index(input bit narrow);
        if (narrow)
            return FIELD_W'($urandom_range(0, 3));
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return FIELD_W'($urandom);
        endcase
    endfunction

    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 11))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // One matrix pair: first-matrix loads, second-matrix merges, then the emit
    task automatic run_set();
        int                 n_load;
        int                 n_merge;
        bit                 narrow;
        bit                 mixed;
        logic [FIELD_W-1:0] r;
        logic [FIELD_W-1:0] c;
        logic [ACT_W-1:0]   act;
        steady  = ($urandom_range(0, 3) == 0);
        narrow  = ($urandom_range(0, 2) == 0);
        mixed   = ($urandom_range(0, 5) == 0);
        n_load  = ($urandom_range(0, 7) == 0) ? $urandom_range(28, 36) : $urandom_range(0, 12);
        n_merge = $urandom_range(0, 12);
        placed_coords.delete();
        while (n_load + n_merge > 0)
        begin
            // mixed sets interleave loads and merges out of the usual order
            if (n_load > 0 && (!mixed || n_merge == 0 || $urandom_range(0, 1) == 0))
            begin
                act = ACT_LOAD;
                n_load--;
            end
            else
            begin
                act = ACT_MERGE;
                n_merge--;
            end
            if (act == ACT_MERGE && placed_coords.size() > 0 && $urandom_range(0, 9) < 7)
            begin
                {r, c} = placed_coords[$urandom_range(0, placed_coords.size() - 1)];
            end
            else
            begin
                r = pick_index(narrow);
                c = pick_index(narrow);
            end
            if ($urandom_range(0, 15) == 0)
                send(ACT_NONE, FIELD_W'($urandom), FIELD_W'($urandom), $urandom);
            send(act, r, c, pick_value());
            placed_coords.push_back({r, c});
        end
        send(ACT_EMIT, FIELD_W'($urandom), FIELD_W'($urandom), $urandom);
        // table is empty now: header only
        if ($urandom_range(0, 9) == 0)
            send(ACT_EMIT, FIELD_W'($urandom), FIELD_W'($urandom), $urandom);
    endtask

    initial
    begin
        int base;
        int set_no;
        int cfg_round;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty table with the reset register values
        steady = 1'b1;
        send(ACT_EMIT, '0, '0, '0);
        drain();
        write_config(16'hFFFF, 16'h0000, CFG_SPARE_HI, 16'hA5A5);

        // Field extremes, wrap-around sums, zero sums, duplicate coordinates
        steady = 1'b0;
        send(ACT_LOAD,  16'h0000, 16'h0000, 32'h8000_0000);
        send(ACT_LOAD,  16'hFFFF, 16'hFFFF, 32'h7FFF_FFFF);
        send(ACT_LOAD,  16'h0000, 16'hFFFF, 32'hFFFF_FFFF);
        send(ACT_LOAD,  16'h0005, 16'h0007, 32'd10);
        send(ACT_LOAD,  16'h0005, 16'h0007, 32'd20);
        send(ACT_MERGE, 16'hFFFF, 16'hFFFF, 32'd1);
        send(ACT_MERGE, 16'h0000, 16'h0000, 32'h8000_0000);
        send(ACT_MERGE, 16'hFFFF, 16'h0000, 32'h1234_5678);
        send(ACT_MERGE, 16'h0000, 16'hFFFF, 32'd1);
        send(ACT_MERGE, 16'h0005, 16'h0007, 32'd1);
        send(ACT_NONE,  16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        send(ACT_EMIT,  16'h0000, 16'h0000, 32'h0);
        drain();
        write_config(16'h0000, 16'hFFFF, CFG_SPARE_LO, 16'hFFFF);

        // Merge into an empty table appends
        send(ACT_MERGE, 16'hAAAA, 16'h5555, 32'h5555_AAAA);
        send(ACT_EMIT,  16'h5555, 16'hAAAA, 32'hAAAA_5555);

        // Random matrix pairs, with register changes between some of them
        base      = sent_items;
        set_no    = 0;
        cfg_round = 0;
        while (sent_items - base < RANDOM_ITEMS)
        begin
            run_set();
            set_no++;
            if (set_no % 6 == 0)
            begin
                drain();
                case (cfg_round % 3)
                    0: write_config(16'hFFFF, 16'hFFFF, CFG_SPARE_HI, 16'h0000);
                    1: write_config(CFG_W'($urandom), CFG_W'($urandom),
                                    $urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI,
                                    CFG_W'($urandom));
                    default: write_config(16'h0000, 16'h0000, CFG_SPARE_LO, 16'h0000);
                endcase
                cfg_round++;
            end
        end

        drain();
        $display("Run covered %0d requests (%0d merges hit a stored entry) in %0d sets,",
                 requests, merge_hits, set_no);
        $display("%0d results checked, %0d headers reported a full table.",
                 results, overflow_headers);
        if (errors == 0)
            $display("** sparse_triplet_matrix_add: PASSED **");
        else
            $display("** sparse_triplet_matrix_add: FAILED **");
        $finish;
    end

endmodule
